// ===== rtl/core/saclru_pkg.sv =====
// Shared constants and field layout for the set-associative read cache.
package saclru_pkg;

    // Function selector carried on s_tuser
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_ACCESS = 1'b1;

    // Access size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Configuration register indexes
    localparam logic CFG_HIT_COST  = 1'b0;
    localparam logic CFG_MISS_COST = 1'b1;

    // Field widths
    localparam int ADDR_W  = 9;
    localparam int SIZE_W  = 2;
    localparam int STAMP_W = 16;
    localparam int MIDX_W  = 7;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = 32;
    localparam int BLK_W   = 64;
    localparam int OFF_W   = 3;
    localparam int BLKNO_W = ADDR_W - OFF_W;
    localparam int HCOST_W = 8;
    localparam int MCOST_W = 10;

    // Input tdata layout, lowest bit up
    localparam int IN_ADDR_LO  = 0;
    localparam int IN_SIZE_LO  = IN_ADDR_LO + ADDR_W;
    localparam int IN_STAMP_LO = IN_SIZE_LO + SIZE_W;
    localparam int IN_MIDX_LO  = IN_STAMP_LO + STAMP_W;
    localparam int IN_WORD_LO  = IN_MIDX_LO + MIDX_W;
    localparam int IN_BITS     = IN_WORD_LO + WORD_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout: read_data, hit, miss, byte, cycle counts
    localparam int OUT_TDATA_W = 5 * CNT_W;

endpackage

// ===== rtl/core/set_assoc_read_cache_lru.sv =====
// Set-associative read-only cache with LRU replacement and backing memory.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    s_tdata: address, access_size, time_stamp,
//                                            mem_index, mem_word; s_tuser: func
//  m_        out        m_tvalid/m_tready    m_tdata: read_data, hit/miss/byte/cycle
//                                            counts; m_tuser: hit
//  cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
//  A load request writes the backing memory and gives no result.
//  An access request scans the ways for a hit and, on a miss, fills the chosen way:
//  one shared tag/time comparator walks the ways one per cycle, and a miss fill reads
//  the two block words through the backing memory read port.
//  After reset a clearing pass zeroes the line store set by set; s_tready stays low.
//  A finished result waits in the output register; a new request is taken meanwhile
//  and holds in its final step until the output register frees.
module set_assoc_read_cache_lru #(
    parameter int SETS      = 4,
    parameter int WAYS      = 2,
    parameter int MEM_WORDS = 128
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // address, access_size, time_stamp, mem_index, mem_word (low bit up)
    input  logic [saclru_pkg::IN_TDATA_W-1:0]  s_tdata,
    // func
    input  logic                               s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // read_data, hit_count, miss_count, byte_count, cycle_count (low bit up)
    output logic [saclru_pkg::OUT_TDATA_W-1:0] m_tdata,
    // hit
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [saclru_pkg::MCOST_W-1:0]     cfg_wdata
);
    import saclru_pkg::*;

    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MEM_AW  = $clog2(MEM_WORDS);
    localparam int NBLOCKS = 1 << BLKNO_W;
    localparam int TAG_MAX = (NBLOCKS - 1) / SETS;
    localparam int TAG_W   = (TAG_MAX > 0) ? $clog2(TAG_MAX + 1) : 1;

    typedef struct packed {
        logic [WAYS-1:0]                valid;
        logic [WAYS-1:0][STAMP_W-1:0]   stamp;
        logic [WAYS-1:0][TAG_W-1:0]     tag;
        logic [WAYS-1:0][BLK_W-1:0]     blk;
    } row_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FILL_A,
        ST_FILL_B,
        ST_FILL_C,
        ST_FINISH
    } state_t;

    // Request fields
    logic [ADDR_W-1:0]  in_addr;
    logic [SIZE_W-1:0]  in_size;
    logic [STAMP_W-1:0] in_stamp;
    logic [MIDX_W-1:0]  in_midx;
    logic [WORD_W-1:0]  in_word;

    assign in_addr  = s_tdata[IN_ADDR_LO  +: ADDR_W];
    assign in_size  = s_tdata[IN_SIZE_LO  +: SIZE_W];
    assign in_stamp = s_tdata[IN_STAMP_LO +: STAMP_W];
    assign in_midx  = s_tdata[IN_MIDX_LO  +: MIDX_W];
    assign in_word  = s_tdata[IN_WORD_LO  +: WORD_W];

    // Control and payload registers
    state_t             state_reg;
    logic [SET_W-1:0]   clr_cnt_reg;
    logic [WAY_W-1:0]   way_cnt_reg;
    logic [WAY_W-1:0]   way_reg;
    logic [WAY_W-1:0]   inv_way_reg;
    logic [WAY_W-1:0]   min_way_reg;
    logic               inv_found_reg;
    logic [STAMP_W-1:0] min_stamp_reg;
    logic               hit_reg;
    logic [SET_W-1:0]   set_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [MEM_AW-1:0]  w0_reg;
    logic [MEM_AW-1:0]  w1_reg;
    logic [WORD_W-1:0]  lo_reg;
    logic [BLK_W-1:0]   blk_reg;
    logic [HCOST_W-1:0] hit_cost_reg;
    logic [MCOST_W-1:0] miss_cost_reg;
    logic [CNT_W-1:0]   hits_reg;
    logic [CNT_W-1:0]   misses_reg;
    logic [CNT_W-1:0]   bytes_reg;
    logic [CNT_W-1:0]   cycles_reg;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    // Memories
    row_t              rows [SETS];
    row_t              row_q;
    logic [WORD_W-1:0] bmem [MEM_WORDS];
    logic [WORD_W-1:0] mem_q;

    logic s_accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Split the block number into set, tag and fill word indexes by constant table
    logic [BLKNO_W-1:0] blkno_in;
    logic [SET_W-1:0]   set_in;
    logic [TAG_W-1:0]   tag_in;
    logic [MEM_AW-1:0]  w0_in;
    logic [MEM_AW-1:0]  w1_in;

    assign blkno_in = in_addr[ADDR_W-1:OFF_W];

    always_comb begin
        set_in = '0;
        tag_in = '0;
        w0_in  = '0;
        w1_in  = '0;
        for (int b = 0; b < NBLOCKS; b++) begin
            if (blkno_in == BLKNO_W'(b)) begin
                set_in = SET_W'(b % SETS);
                tag_in = TAG_W'(b / SETS);
                w0_in  = MEM_AW'((2 * b) % MEM_WORDS);
                w1_in  = MEM_AW'((2 * b + 1) % MEM_WORDS);
            end
        end
    end

    // Load index: ignore loads beyond the memory
    logic [MEM_AW-1:0] midx_w;
    logic              load_ok;
    assign midx_w  = MEM_AW'(in_midx);
    assign load_ok = 32'(in_midx) < 32'(MEM_WORDS);

    // Current way under the comparator
    logic             cur_valid;
    logic [TAG_W-1:0] cur_tag;
    logic [STAMP_W-1:0] cur_stamp;
    logic             cur_match;
    logic             last_way;

    assign cur_valid = row_q.valid[way_cnt_reg];
    assign cur_tag   = row_q.tag[way_cnt_reg];
    assign cur_stamp = row_q.stamp[way_cnt_reg];
    assign cur_match = cur_valid && (cur_tag == tag_reg);
    assign last_way  = (way_cnt_reg == WAY_W'(WAYS - 1));

    // Assemble read data: bytes past the block end read as zero
    logic [2:0]        nbytes;
    logic [WORD_W-1:0] rd_data;

    always_comb begin
        case (size_reg)
            SIZE_BYTE: nbytes = 3'd1;
            SIZE_HALF: nbytes = 3'd2;
            SIZE_WORD: nbytes = 3'd4;
            default:   nbytes = 3'd0;
        endcase
    end

    always_comb begin
        logic [OFF_W:0] pos;
        rd_data = '0;
        for (int k = 0; k < 4; k++) begin
            pos = {1'b0, off_reg} + (OFF_W + 1)'(k);
            if ((3'(k) < nbytes) && !pos[OFF_W]) begin
                rd_data[8*k +: 8] = blk_reg[8*pos[OFF_W-1:0] +: 8];
            end
        end
    end

    // Result and counter update
    logic               out_load;
    logic [10:0]        cost_sum;
    logic [CNT_W-1:0]   hits_new;
    logic [CNT_W-1:0]   misses_new;
    logic [CNT_W-1:0]   bytes_new;
    logic [CNT_W-1:0]   cycles_new;

    assign out_load   = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign cost_sum   = 11'(hit_cost_reg) + (hit_reg ? 11'd0 : 11'(miss_cost_reg));
    assign hits_new   = hits_reg + CNT_W'(hit_reg);
    assign misses_new = misses_reg + CNT_W'(!hit_reg);
    assign bytes_new  = bytes_reg + CNT_W'(nbytes);
    assign cycles_new = cycles_reg + CNT_W'(cost_sum);

    // Line store write: clearing pass, or the updated row on finish
    logic             row_we;
    logic [SET_W-1:0] row_waddr;
    logic [SET_W-1:0] row_raddr;
    row_t             row_wdata;

    always_comb begin
        row_we    = 1'b0;
        row_waddr = set_reg;
        row_wdata = row_q;
        if (state_reg == ST_CLEAR) begin
            row_we    = 1'b1;
            row_waddr = clr_cnt_reg;
            row_wdata = '0;
        end else if (out_load) begin
            row_we = 1'b1;
            row_wdata.stamp[way_reg] = stamp_reg;
            if (!hit_reg) begin
                row_wdata.valid[way_reg] = 1'b1;
                row_wdata.tag[way_reg]   = tag_reg;
                row_wdata.blk[way_reg]   = blk_reg;
            end
        end
    end

    assign row_raddr = s_accept ? set_in : set_reg;

    always_ff @(posedge aclk) begin
        if (row_we) begin
            rows[row_waddr] <= row_wdata;
        end
        row_q <= rows[row_raddr];
    end

    // Backing memory: loads write through one port, fills read through the other
    always_ff @(posedge aclk) begin
        if (s_accept && (s_tuser == FUNC_LOAD) && load_ok) begin
            bmem[midx_w] <= in_word;
        end
        mem_q <= bmem[(state_reg == ST_FILL_A) ? w0_reg : w1_reg];
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            way_cnt_reg   <= '0;
            way_reg       <= '0;
            inv_way_reg   <= '0;
            min_way_reg   <= '0;
            inv_found_reg <= 1'b0;
            min_stamp_reg <= '0;
            hit_reg       <= 1'b0;
            hit_cost_reg  <= HCOST_W'(1);
            miss_cost_reg <= MCOST_W'(100);
            hits_reg      <= '0;
            misses_reg    <= '0;
            bytes_reg     <= '0;
            cycles_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tuser_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_HIT_COST:  hit_cost_reg  <= cfg_wdata[HCOST_W-1:0];
                    CFG_MISS_COST: miss_cost_reg <= cfg_wdata;
                    default:       ;
                endcase
            end

            // Drop the result once taken, unless a new one replaces it
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
                    if (clr_cnt_reg == SET_W'(SETS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept && (s_tuser == FUNC_ACCESS)) begin
                        set_reg       <= set_in;
                        tag_reg       <= tag_in;
                        off_reg       <= in_addr[OFF_W-1:0];
                        size_reg      <= in_size;
                        stamp_reg     <= in_stamp;
                        w0_reg        <= w0_in;
                        w1_reg        <= w1_in;
                        way_cnt_reg   <= '0;
                        inv_found_reg <= 1'b0;
                        hit_reg       <= 1'b0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // One way per cycle: tag match, first invalid, least recent
                    if (cur_match) begin
                        hit_reg   <= 1'b1;
                        way_reg   <= way_cnt_reg;
                        blk_reg   <= row_q.blk[way_cnt_reg];
                        state_reg <= ST_FINISH;
                    end else begin
                        if (!cur_valid && !inv_found_reg) begin
                            inv_found_reg <= 1'b1;
                            inv_way_reg   <= way_cnt_reg;
                        end
                        if ((way_cnt_reg == '0) || (cur_stamp < min_stamp_reg)) begin
                            min_stamp_reg <= cur_stamp;
                            min_way_reg   <= way_cnt_reg;
                        end
                        if (last_way) begin
                            state_reg <= ST_FILL_A;
                        end else begin
                            way_cnt_reg <= way_cnt_reg + WAY_W'(1);
                        end
                    end
                end
                ST_FILL_A: begin
                    way_reg   <= inv_found_reg ? inv_way_reg : min_way_reg;
                    state_reg <= ST_FILL_B;
                end
                ST_FILL_B: begin
                    lo_reg    <= mem_q;
                    state_reg <= ST_FILL_C;
                end
                ST_FILL_C: begin
                    blk_reg   <= {mem_q, lo_reg};
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    // Hold until the output register frees
                    if (out_load) begin
                        hits_reg     <= hits_new;
                        misses_reg   <= misses_new;
                        bytes_reg    <= bytes_new;
                        cycles_reg   <= cycles_new;
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= hit_reg;
                        m_tdata_reg  <= {cycles_new, bytes_new, misses_new, hits_new, rd_data};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Each result counts exactly one hit or one miss
    a_one_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> ((hits_reg - $past(hits_reg)) + (misses_reg - $past(misses_reg)))
                     == CNT_W'(1))
        else $error("hit/miss counters did not advance by one");

    // Byte counter advances by at most a word per result
    a_byte_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (bytes_reg - $past(bytes_reg)) <= CNT_W'(4))
        else $error("byte counter advanced too far");

    // A hit adds only the hit cost to the cycle counter
    a_hit_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && hit_reg) |=> (cycles_reg - $past(cycles_reg)) == CNT_W'($past(hit_cost_reg)))
        else $error("cycle counter wrong on hit");

    // Way counter stays inside the set while scanning
    a_way_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (32'(way_cnt_reg) < 32'(WAYS)))
        else $error("way counter out of range");

endmodule
